// ===== design/ohm_pkg.sv =====
// Package for the oversampled ohmmeter core.
// Holds field widths, group size and the reset value of the reference register.
// No dependencies.
package ohm_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int SUM_W      = 14;
	localparam int COUNT_W    = 4;
	localparam int CODE_W     = 12;
	localparam int REF_W      = 16;
	localparam int DEN_W      = 13;
	localparam int PROD_W     = CODE_W + REF_W;
	localparam int Q_FRAC_W   = 4;
	localparam int NUM_W      = PROD_W + Q_FRAC_W;
	localparam int RES_W      = 30;

	localparam logic [COUNT_W-1:0] GROUP_LAST = COUNT_W'(15);
	localparam logic [DEN_W-1:0]   FULL_SCALE = DEN_W'(4096);
	localparam logic [REF_W-1:0]   REF_RESET  = REF_W'(983);

	localparam logic [CODE_W-1:0] CODE_MAX = CODE_W'(4092);
	localparam logic [RES_W-1:0]  RES_MAX  = RES_W'(1072676880);

endpackage

// ===== design/oversampled_ohmmeter_core.sv =====
// Top level of the oversampled ohmmeter: sample accumulator, bit-serial
// multiplier and bit-serial restoring divider. Depends on ohm_pkg.
//
//  channel | signals                              | beat
//  --------+--------------------------------------+--------------------------------
//  in      | in_valid, in_stall, sample           | one raw 10-bit conversion
//  out     | out_valid, out_stall,                | code and Q4 resistance,
//          |   oversampled_code, resistance_q4    |   one per 16 input beats
//  cfg     | cfg_wr_en, cfg_wr_data               | reference resistor, ohms
//
// Fifteen of every sixteen input beats cause no result.
// The sixteenth starts the arithmetic: shift-add multiply, one bit of the code
// per cycle, then restoring division, one quotient bit per cycle, then the
// load of the output register. in_stall is high during the arithmetic and while
// the result waits for a full output register. Reset clears the sum, count,
// engine and output valid.
module oversampled_ohmmeter_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ohm_pkg::SAMPLE_W-1:0]   sample,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ohm_pkg::CODE_W-1:0]     oversampled_code,
	output logic [ohm_pkg::RES_W-1:0]      resistance_q4,
	input  logic                           cfg_wr_en,
	input  logic [ohm_pkg::REF_W-1:0]      cfg_wr_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(ohm_pkg::CODE_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(ohm_pkg::NUM_W - 1);

	logic [1:0]                        state_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [ohm_pkg::REF_W-1:0]         ref_q;
	logic [ohm_pkg::SUM_W-1:0]         sum_q;
	logic [ohm_pkg::COUNT_W-1:0]       count_q;
	logic [ohm_pkg::CODE_W-1:0]        code_q;
	logic [ohm_pkg::CODE_W-1:0]        mplier_q;
	logic [ohm_pkg::PROD_W-1:0]        mcand_q;
	logic [ohm_pkg::PROD_W-1:0]        acc_q;
	logic [ohm_pkg::NUM_W-1:0]         num_q;
	logic [ohm_pkg::DEN_W-1:0]         den_q;
	logic [ohm_pkg::DEN_W-1:0]         rem_q;
	logic                              out_valid_q;
	logic [ohm_pkg::CODE_W-1:0]        out_code_q;
	logic [ohm_pkg::RES_W-1:0]         out_res_q;

	logic                              in_beat;
	logic [ohm_pkg::SUM_W-1:0]         sum_next;
	logic [ohm_pkg::PROD_W-1:0]        acc_next;
	logic [ohm_pkg::DEN_W:0]           rem_sh;
	logic                              q_bit;
	logic [ohm_pkg::DEN_W-1:0]         rem_next;
	logic                              out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign sum_next  = sum_q + ohm_pkg::SUM_W'(sample);
	assign acc_next  = mplier_q[0] ? (acc_q + mcand_q) : acc_q;
	assign rem_sh    = {rem_q, num_q[ohm_pkg::NUM_W-1]};
	assign q_bit     = (rem_sh >= {1'b0, den_q});
	assign rem_next  = q_bit ? ohm_pkg::DEN_W'(rem_sh - {1'b0, den_q})
	                         : ohm_pkg::DEN_W'(rem_sh);
	assign out_free  = !out_valid_q || !out_stall;

	assign out_valid        = out_valid_q;
	assign oversampled_code = out_code_q;
	assign resistance_q4    = out_res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= ohm_pkg::REF_RESET;
		end else if (cfg_wr_en) begin
			ref_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			count_q <= '0;
		end else if (in_beat) begin
			if (count_q == ohm_pkg::GROUP_LAST) begin
				sum_q   <= '0;
				count_q <= '0;
			end else begin
				sum_q   <= sum_next;
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && count_q == ohm_pkg::GROUP_LAST) begin
						state_q <= ST_MUL;
						cnt_q   <= '0;
					end
				end
				ST_MUL: begin
					if (cnt_q == MUL_LAST) begin
						state_q <= ST_DIV;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_beat && count_q == ohm_pkg::GROUP_LAST) begin
					code_q   <= sum_next[ohm_pkg::SUM_W-1 -: ohm_pkg::CODE_W];
					mplier_q <= sum_next[ohm_pkg::SUM_W-1 -: ohm_pkg::CODE_W];
					den_q    <= ohm_pkg::FULL_SCALE
					            - ohm_pkg::DEN_W'(sum_next[ohm_pkg::SUM_W-1 -: ohm_pkg::CODE_W]);
					mcand_q  <= ohm_pkg::PROD_W'(ref_q);
					acc_q    <= '0;
				end
			end
			ST_MUL: begin
				acc_q    <= acc_next;
				mcand_q  <= {mcand_q[ohm_pkg::PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[ohm_pkg::CODE_W-1:1]};
				if (cnt_q == MUL_LAST) begin
					num_q <= {acc_next, {ohm_pkg::Q_FRAC_W{1'b0}}};
					rem_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q <= rem_next;
				num_q <= {num_q[ohm_pkg::NUM_W-2:0], q_bit};
			end
			ST_DONE: begin
				if (out_free) begin
					out_code_q <= code_q;
					out_res_q  <= num_q[ohm_pkg::RES_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== design/ohm_checker.sv =====
// Port-level checker for oversampled_ohmmeter_core, bound to the top level.
// Depends on ohm_pkg.
module ohm_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [ohm_pkg::CODE_W-1:0]     oversampled_code,
	input logic [ohm_pkg::RES_W-1:0]      resistance_q4
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(oversampled_code)
			&& $stable(resistance_q4))
		else $error("stalled result beat changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> oversampled_code <= ohm_pkg::CODE_MAX
			&& resistance_q4 <= ohm_pkg::RES_MAX)
		else $error("result out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid))
		else $error("input stall without a preceding beat");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while input side was open");

endmodule

bind oversampled_ohmmeter_core ohm_checker u_ohm_checker (.*);

// ===== tb/testbench.sv =====
// Testbench for oversampled_ohmmeter_core: directed and random sample beats on the
// valid/stall channels, with a scoreboard fed by an in-bench divider predictor.
// Depends on ohm_pkg and the core RTL only.
`timescale 1ns / 100ps

module testbench;

	localparam int GROUP_LEN    = 16;
	localparam int SCALE_CODES  = 4096;
	localparam int ENGINE_WAIT  = 60;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int REPORT_MAX   = 10;

	typedef enum int {
		MIX_UNIFORM,
		MIX_ZERO,
		MIX_FULL,
		MIX_TINY,
		MIX_HIGH
	} sample_mix_t;

	typedef struct packed {
		logic [ohm_pkg::CODE_W-1:0] code;
		logic [ohm_pkg::RES_W-1:0]  res_q4;
	} ohm_result_t;

	logic                         clk         = 1'b0;
	logic                         arst_n      = 1'b0;
	logic                         in_valid    = 1'b0;
	logic                         in_stall;
	logic [ohm_pkg::SAMPLE_W-1:0] sample      = '0;
	logic                         out_valid;
	logic                         out_stall   = 1'b0;
	logic [ohm_pkg::CODE_W-1:0]   oversampled_code;
	logic [ohm_pkg::RES_W-1:0]    resistance_q4;
	logic                         cfg_wr_en   = 1'b0;
	logic [ohm_pkg::REF_W-1:0]    cfg_wr_data = '0;

	ohm_result_t                  expected_results[$];
	logic [ohm_pkg::REF_W-1:0]    ref_ohms;
	logic [ohm_pkg::SUM_W-1:0]    group_sum;
	int                           group_count;
	int                           mismatches  = 0;
	int                           cycle_count = 0;
	int                           send_idle_pct = 0;
	int                           recv_stall_pct = 0;

	oversampled_ohmmeter_core u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.sample           (sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.oversampled_code (oversampled_code),
		.resistance_q4    (resistance_q4),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	function automatic logic [ohm_pkg::RES_W-1:0] divider_resistance_q4(
		input logic [ohm_pkg::CODE_W-1:0] code,
		input logic [ohm_pkg::REF_W-1:0]  r_ohms
	);
		logic [63:0] num;
		logic [63:0] den;
		num = 64'(code) * 64'(r_ohms) * 64'd16;
		den = 64'(SCALE_CODES) - 64'(code);
		return ohm_pkg::RES_W'(num / den);
	endfunction

	task automatic accumulate_sample(input logic [ohm_pkg::SAMPLE_W-1:0] v);
		ohm_result_t r;
		group_sum = group_sum + ohm_pkg::SUM_W'(v);
		group_count++;
		if (group_count == GROUP_LEN) begin
			r.code   = ohm_pkg::CODE_W'(group_sum >> 2);
			r.res_q4 = divider_resistance_q4(r.code, ref_ohms);
			expected_results.push_back(r);
			group_sum   = '0;
			group_count = 0;
		end
	endtask

	task automatic report_mismatch(input string what, input longint want, input longint got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch %0d: %s expected %0d got %0d", mismatches, what, want, got);
	endtask

	always @(negedge clk) begin
		ohm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, code", -1, oversampled_code);
			end else begin
				want = expected_results.pop_front();
				if (oversampled_code !== want.code)
					report_mismatch("oversampled_code", want.code, oversampled_code);
				if (resistance_q4 !== want.res_q4)
					report_mismatch("resistance_q4", want.res_q4, resistance_q4);
			end
		end
	end

	// Call at a rising edge; returns at the edge where the beat is taken.
	task automatic send_sample(input logic [ohm_pkg::SAMPLE_W-1:0] v);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			sample   <= ohm_pkg::SAMPLE_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= v;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		accumulate_sample(v);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic write_ref(input logic [ohm_pkg::REF_W-1:0] v);
		hold_until_drained();
		repeat (ENGINE_WAIT) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		ref_ohms = v;
	endtask

	function automatic logic [ohm_pkg::SAMPLE_W-1:0] pick_sample(input sample_mix_t mix);
		case (mix)
			MIX_ZERO: return '0;
			MIX_FULL: return '1;
			MIX_TINY: return ohm_pkg::SAMPLE_W'($urandom_range(3));
			MIX_HIGH: return ohm_pkg::SAMPLE_W'($urandom_range(1023, 960));
			default:  return ohm_pkg::SAMPLE_W'($urandom_range(1023));
		endcase
	endfunction

	// Reset reference with full-scale samples gives the largest code.
	task automatic test_reset_reference();
		repeat (GROUP_LEN) send_sample('1);
		hold_until_drained();
	endtask

	// Change the reference mid-group; the new value applies to this group.
	task automatic test_midgroup_reference();
		repeat (GROUP_LEN / 2) send_sample('1);
		write_ref('1);
		repeat (GROUP_LEN / 2) send_sample('1);
		hold_until_drained();
	endtask

	task automatic test_random_traffic(
		input int                        idle_pct,
		input int                        stall_pct,
		input logic [ohm_pkg::REF_W-1:0] r_ohms,
		input int                        beats
	);
		sample_mix_t mix;
		int          roll;
		write_ref(r_ohms);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		mix = MIX_UNIFORM;
		for (int i = 0; i < beats; i++) begin
			if (group_count == 0) begin
				roll = $urandom_range(99);
				if (roll < 60)      mix = MIX_UNIFORM;
				else if (roll < 70) mix = MIX_ZERO;
				else if (roll < 80) mix = MIX_FULL;
				else if (roll < 90) mix = MIX_TINY;
				else                mix = MIX_HIGH;
			end
			send_sample(pick_sample(mix));
			if ($urandom_range(99) < 2)
				hold_until_drained();
		end
		hold_until_drained();
		send_idle_pct  = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		ref_ohms    = ohm_pkg::REF_RESET;
		group_sum   = '0;
		group_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_reference();
		test_midgroup_reference();

		test_random_traffic(0,  0,  ohm_pkg::REF_W'($urandom_range(65535)), 175);
		test_random_traffic(0,  0,  '0,                                     175);
		test_random_traffic(57, 0,  ohm_pkg::REF_W'(1),                     175);
		test_random_traffic(57, 0,  '1,                                     175);
		test_random_traffic(0,  57, ohm_pkg::REF_W'($urandom_range(65535)), 175);
		test_random_traffic(0,  57, ohm_pkg::REF_RESET,                     175);
		test_random_traffic(38, 38, ohm_pkg::REF_W'($urandom_range(65535)), 175);
		test_random_traffic(38, 38, '1,                                     175);

		hold_until_drained();
		repeat (ENGINE_WAIT) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
